/* rtl/core/ppac_pkg.sv */
`default_nettype none

package ppac_pkg;

   // Fixed field widths
   localparam int SAMPLE_W    = 12;
   localparam int SUM_W       = 20;
   localparam int MV_W        = 12;
   localparam int PH_W        = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   // Queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;

   // Parameter defaults
   localparam int SAMPLES_PER_READING_DEF = 16;
   localparam int ADC_FULL_SCALE_DEF      = 4095;
   localparam int VREF_MV_DEF             = 3300;

   // Calibration constants (pH in hundredths)
   localparam logic [PH_W-1:0] PH_MID = 11'd700;
   localparam logic [PH_W-1:0] PH_MAX     = 11'd1400;
   localparam int PH_SPAN       = 300;   // 7.00 - 4.00 in hundredths
   localparam int PH_OFFSET     = 700;
   localparam int SAT_FACTOR    = 2802;  // 2 * (PH_MAX + 1)
   localparam int CAL_MIN_MV    = 10;

   // Register reset values
   localparam logic [MV_W-1:0] NEUTRAL_MV_RST = 12'd2500;
   localparam logic [MV_W-1:0] ACIDIC_MV_RST  = 12'd1800;
   localparam logic [PH_W-1:0] SIM_PH_REF_RST = 11'd700;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEUTRAL_MV      = 2'd0,
      CSR_ACIDIC_MV       = 2'd1,
      CSR_SIMULATE_ENABLE = 2'd2,
      CSR_SIM_PH_REF      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [MV_W-1:0] neutral_mv;
      logic [MV_W-1:0] acidic_mv;
      logic            simulate_enable;
      logic [PH_W-1:0] sim_ph_ref;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIFF,
      ST_SCALE,
      ST_TOTAL,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } back_state_type;

endpackage

`default_nettype wire

/* rtl/core/ppac_queue.sv */
`default_nettype none

module ppac_queue
   import ppac_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   input  wire logic [SUM_W-1:0] wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_ready,
   output logic [SUM_W-1:0]      rd_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [SUM_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push, pop;

   assign wr_ready = (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (fill_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/ppac_front.sv */
`default_nettype none

module ppac_front
   import ppac_pkg::*;
#(
   parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [SAMPLE_W-1:0] req_adc_sample,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output logic [SUM_W-1:0]         push_sum
);

   localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             closing;
   logic [SUM_W-1:0] sum_next;

   // Stall whole input while the queue has no room
   assign req_stall = !push_ready;
   assign accept    = req_valid && !req_stall;
   assign closing   = (count_ff == CNT_W'(SAMPLES_PER_READING - 1));
   assign sum_next  = sum_ff + SUM_W'(req_adc_sample);

   assign push_valid = accept && closing;
   assign push_sum   = sum_next;

   // Window accumulation
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (closing) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/ppac_back.sv */
`default_nettype none

module ppac_back
   import ppac_pkg::*;
#(
   parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF,
   parameter int ADC_FULL_SCALE      = ADC_FULL_SCALE_DEF,
   parameter int VREF_MV             = VREF_MV_DEF
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             pop_valid,
   output logic                  pop_ready,
   input  wire logic [SUM_W-1:0] pop_sum,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [PH_W-1:0]       rsp_ph_hundredths,
   output logic                  rsp_cal_degenerate,
   output logic                  rsp_ph_ok
);

   // Datapath widths follow from the window length and scale
   localparam longint NF      = longint'(SAMPLES_PER_READING) * longint'(ADC_FULL_SCALE);
   localparam int     NF_W    = $clog2(NF + 1);
   localparam int     SR_W    = SUM_W + $clog2(VREF_MV + 1);
   localparam int     NMNF_W  = MV_W + NF_W;
   localparam int     DIFF_W  = ((SR_W > NMNF_W) ? SR_W : NMNF_W) + 1;
   localparam int     DEN_W   = NF_W + MV_W;
   localparam int     TW      = DIFF_W + 11;
   localparam int     UW      = TW + 1;
   localparam int     STEP_W  = $clog2(PH_W);
   localparam int     D_W     = MV_W + 1;

   localparam logic signed [TW-1:0] SPAN_S   = TW'(PH_SPAN);
   localparam logic signed [TW-1:0] OFFSET_S = TW'(PH_OFFSET);
   localparam logic signed [D_W-1:0] CAL_LO  = -D_W'(CAL_MIN_MV);
   localparam logic signed [D_W-1:0] CAL_HI  = D_W'(CAL_MIN_MV);

   back_state_type state_ff, state_in;

   logic [SUM_W-1:0]         sum_ff;
   logic [SR_W-1:0]          sr_ff;
   logic [NMNF_W-1:0]        nmnf_ff;
   logic [DEN_W-1:0]         den_ff;
   logic                     neg_ff;
   logic                     degen_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [TW-1:0]     num_ff;
   logic signed [TW-1:0]     den7_ff;
   logic [UW-1:0]            sat_lim_ff;
   logic signed [TW-1:0]     total_ff;
   logic                     pos_ff;
   logic                     sat_ff;
   logic [UW-1:0]            rem_ff;
   logic [UW-1:0]            dvs_ff;
   logic [PH_W-1:0]          quo_ff;
   logic [STEP_W-1:0]        step_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PH_W-1:0]          ph_ff;
   logic                     degen_out_ff;
   logic                     ok_ff;

   logic signed [D_W-1:0]    cal_diff;
   logic [MV_W-1:0]          cal_abs;
   logic [UW-1:0]            rem_start;
   logic                     div_ge;
   logic                     out_free;
   logic                     out_load;
   logic [PH_W-1:0]          ph_sel;
   logic                     degen_sel;
   logic                     ok_sel;

   // Calibration span, sign and degenerate check
   assign cal_diff = $signed({1'b0, cfg.neutral_mv}) - $signed({1'b0, cfg.acidic_mv});
   assign cal_abs  = cal_diff[D_W-1] ? MV_W'(-cal_diff) : MV_W'(cal_diff);
   assign rem_start = UW'({total_ff, 1'b0}) + UW'(den_ff);
   assign div_ge   = (rem_ff >= dvs_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_TOTAL;
         ST_TOTAL: state_in = ST_PREP;
         ST_PREP:  state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      pop_ready = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: pop_ready = 1'b1;
         ST_OUT:  out_load  = out_free;
         default: begin
            pop_ready = 1'b0;
            out_load  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Arithmetic sequence: products, signed difference, scale, total, divide
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            sum_ff <= pop_sum;
         end
         ST_MUL: begin
            sr_ff    <= SR_W'(sum_ff) * SR_W'(VREF_MV);
            nmnf_ff  <= NMNF_W'(cfg.neutral_mv) * NMNF_W'(NF);
            den_ff   <= DEN_W'(cal_abs) * DEN_W'(NF);
            neg_ff   <= cal_diff[D_W-1];
            degen_ff <= (cal_diff > CAL_LO) && (cal_diff < CAL_HI);
         end
         ST_DIFF: begin
            if (neg_ff) begin
               diff_ff <= $signed(DIFF_W'(nmnf_ff)) - $signed(DIFF_W'(sr_ff));
            end else begin
               diff_ff <= $signed(DIFF_W'(sr_ff)) - $signed(DIFF_W'(nmnf_ff));
            end
         end
         ST_SCALE: begin
            num_ff     <= TW'(diff_ff) * SPAN_S;
            den7_ff    <= $signed(TW'(den_ff)) * OFFSET_S;
            sat_lim_ff <= UW'(den_ff) * UW'(SAT_FACTOR);
         end
         ST_TOTAL: begin
            total_ff <= num_ff + den7_ff;
         end
         ST_PREP: begin
            pos_ff  <= !total_ff[TW-1] && (total_ff != '0);
            sat_ff  <= (rem_start >= sat_lim_ff);
            rem_ff  <= rem_start;
            dvs_ff  <= UW'(den_ff) << PH_W;
            quo_ff  <= '0;
            step_ff <= STEP_W'(PH_W - 1);
         end
         ST_DIV: begin
            if (div_ge) begin
               rem_ff <= rem_ff - dvs_ff;
            end
            quo_ff  <= {quo_ff[PH_W-2:0], div_ge};
            dvs_ff  <= dvs_ff >> 1;
            step_ff <= step_ff - 1'b1;
         end
         default: begin
            sum_ff <= sum_ff;
         end
      endcase
   end

   // Result selection
   always_comb begin
      if (cfg.simulate_enable) begin
         ph_sel    = cfg.sim_ph_ref;
         degen_sel = 1'b0;
         ok_sel    = (cfg.sim_ph_ref <= PH_MAX);
      end else begin
         degen_sel = degen_ff;
         ok_sel    = 1'b1;
         if (degen_ff) begin
            ph_sel = PH_MID;
         end else if (!pos_ff) begin
            ph_sel = '0;
         end else if (sat_ff) begin
            ph_sel = PH_MAX;
         end else begin
            ph_sel = quo_ff;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         ph_ff        <= ph_sel;
         degen_out_ff <= degen_sel;
         ok_ff        <= ok_sel;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ph_hundredths  = ph_ff;
   assign rsp_cal_degenerate = degen_out_ff;
   assign rsp_ph_ok          = ok_ff;

endmodule

`default_nettype wire

/* rtl/core/ph_probe_average_calibrate.sv */
// pH probe averager with two-point linear calibration.
//
// Input channel (req_): one 12-bit converter sample per transfer. Samples are
// summed over a window of SAMPLES_PER_READING transfers; the transfer that
// closes the window queues the sum for conversion. Other transfers give no result.
// Result channel (rsp_): one transfer per closed window carrying pH in
// hundredths, the degenerate-calibration flag and the in-range flag.
// Configuration (csr_): always ready; index selects neutral_mv, acidic_mv,
// simulate_enable or sim_ph_ref. Write only while the block is idle.
//
// A closing sample's sum passes through the queue to the conversion sequencer
// (five arithmetic steps and a restoring divider for the rounded 11-bit
// quotient) and then the output register. Input takes one sample per
// cycle while the two-entry sum queue has room; the front keeps summing
// the next window while the sequencer converts the last.
// A stalled result holds in the output register; conversions behind it wait
// in the queue, and once the queue is full req_stall rises.
// Reset (synchronous) clears the window, the queue, the sequencer, the
// pending result and restores the register defaults.

`default_nettype none

module ph_probe_average_calibrate
   import ppac_pkg::*;
#(
   parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF,
   parameter int ADC_FULL_SCALE      = ADC_FULL_SCALE_DEF,
   parameter int VREF_MV             = VREF_MV_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [SAMPLE_W-1:0]    req_adc_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [PH_W-1:0]             rsp_ph_hundredths,
   output logic                        rsp_cal_degenerate,
   output logic                        rsp_ph_ok,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type          cfg_ff;
   logic             push_valid, push_ready;
   logic [SUM_W-1:0] push_sum;
   logic             pop_valid, pop_ready;
   logic [SUM_W-1:0] pop_sum;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neutral_mv      <= NEUTRAL_MV_RST;
         cfg_ff.acidic_mv       <= ACIDIC_MV_RST;
         cfg_ff.simulate_enable <= 1'b0;
         cfg_ff.sim_ph_ref      <= SIM_PH_REF_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_NEUTRAL_MV:      cfg_ff.neutral_mv      <= csr_data[MV_W-1:0];
            CSR_ACIDIC_MV:       cfg_ff.acidic_mv       <= csr_data[MV_W-1:0];
            CSR_SIMULATE_ENABLE: cfg_ff.simulate_enable <= csr_data[0];
            CSR_SIM_PH_REF:      cfg_ff.sim_ph_ref      <= csr_data[PH_W-1:0];
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   ppac_front #(
      .SAMPLES_PER_READING(SAMPLES_PER_READING)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_adc_sample (req_adc_sample),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_sum       (push_sum)
   );

   ppac_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  (push_sum),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_data  (pop_sum)
   );

   ppac_back #(
      .SAMPLES_PER_READING(SAMPLES_PER_READING),
      .ADC_FULL_SCALE     (ADC_FULL_SCALE),
      .VREF_MV            (VREF_MV)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_sum            (pop_sum),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ph_hundredths  (rsp_ph_hundredths),
      .rsp_cal_degenerate (rsp_cal_degenerate),
      .rsp_ph_ok          (rsp_ph_ok)
   );

endmodule

`default_nettype wire

/* rtl/core/ppac_checker.sv */
`default_nettype none

module ppac_checker
   import ppac_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [PH_W-1:0]  rsp_ph_hundredths,
   input wire logic             rsp_cal_degenerate,
   input wire logic             rsp_ph_ok
);

   // No result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ph_hundredths)
         && $stable(rsp_cal_degenerate) && $stable(rsp_ph_ok))
      else $error("stalled result changed");

   // In-range flag agrees with the reported value
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ph_ok == (rsp_ph_hundredths <= PH_MAX)))
      else $error("ph_ok disagrees with value");

   // Degenerate calibration reports neutral pH
   a_degen_neutral: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cal_degenerate |-> rsp_ph_hundredths == PH_MID)
      else $error("degenerate result is not neutral pH");

endmodule

bind ph_probe_average_calibrate ppac_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_ph_hundredths  (rsp_ph_hundredths),
   .rsp_cal_degenerate (rsp_cal_degenerate),
   .rsp_ph_ok          (rsp_ph_ok)
);

`default_nettype wire
